### src/pwf_pkg.sv
// Shared types and constants for the PID wall follower core.
// No dependencies; used by pwf_pid and pid_wall_follower_core.
package pwf_pkg;

  localparam int CFG_DIST_W  = 14;
  localparam int GAIN_W      = 20;
  localparam int IGAIN_W     = 16;
  localparam int SPEED_W     = 11;
  localparam int ANGLE_W     = 8;
  localparam int DEG_W       = 9;
  localparam int CFG_DATA_W  = 20;
  localparam int CFG_IDX_W   = 3;
  localparam int DIFF_W      = 18;
  localparam int ERR_W       = 16;
  localparam int SUM_W       = 32;
  localparam int CTL_W       = 50;
  localparam int CMD_IDX_W   = 2;
  localparam int CMD_CNT_W   = 3;

  localparam logic [CFG_DIST_W-1:0] TARGET_RST  = 14'd1000;
  localparam logic [CFG_DIST_W-1:0] WALL_RST    = 14'd1500;
  localparam logic [GAIN_W-1:0]     PROP_RST    = 20'd65536;
  localparam logic [IGAIN_W-1:0]    INT_RST     = 16'd66;
  localparam logic [GAIN_W-1:0]     DERIV_RST   = 20'd104858;
  localparam logic [SPEED_W-1:0]    CRUISE_RST  = 11'd200;
  localparam logic [SPEED_W-1:0]    WANDER_RST  = 11'd300;
  localparam logic [ANGLE_W-1:0]    TURN_RST    = 8'd45;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET = 3'd0,
    REG_WALL   = 3'd1,
    REG_PROP   = 3'd2,
    REG_INT    = 3'd3,
    REG_DERIV  = 3'd4,
    REG_CRUISE = 3'd5,
    REG_WANDER = 3'd6,
    REG_TURN   = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    IDLE_TURN_POS = 2'd0,
    IDLE_TURN_NEG = 2'd1,
    IDLE_WANDER   = 2'd2
  } idle_cmd_t;

  typedef enum logic [2:0] {
    CMD_STOP  = 3'd0,
    CMD_FTURN = 3'd1,
    CMD_LEFT  = 3'd2,
    CMD_RIGHT = 3'd3,
    CMD_IDLE  = 3'd4
  } cmd_t;

  localparam logic KIND_SPEED = 1'b0;
  localparam logic KIND_TURN  = 1'b1;

  typedef struct packed {
    logic      front_wall;
    logic      left_wall;
    logic      right_wall;
    idle_cmd_t idle_cmd;
  } tick_flags_t;

  // pipeline advance controls from the top level to the PID datapaths
  typedef struct packed {
    logic upd;
    logic ld2;
    logic ld3;
    logic ld4;
    logic ld5;
  } pwf_adv_t;

endpackage

### src/pwf_pid.sv
// One side's PID loop: error/integral state, gain products, rounding and clamp.
// Depends on pwf_pkg; instantiated twice by pid_wall_follower_core.
module pwf_pid #(
  parameter int DISTANCE_BITS = 14
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pwf_pkg::pwf_adv_t                   adv,
  input  logic                                wall,
  input  logic [DISTANCE_BITS-1:0]            reading,
  input  logic [pwf_pkg::CFG_DIST_W-1:0]      target,
  input  logic [pwf_pkg::GAIN_W-1:0]          prop,
  input  logic [pwf_pkg::IGAIN_W-1:0]         intg,
  input  logic [pwf_pkg::GAIN_W-1:0]          deriv,
  input  logic [pwf_pkg::SPEED_W-1:0]         cruise,
  output logic [pwf_pkg::SPEED_W-1:0]         red,
  output logic                                ctl_pos
);

  logic signed [pwf_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [pwf_pkg::ERR_W-1:0]  last_r;
  logic signed [pwf_pkg::DIFF_W-1:0] dist_diff;
  logic signed [pwf_pkg::ERR_W-1:0]  err;
  logic [pwf_pkg::SUM_W:0]           sum_ext;
  logic [pwf_pkg::ERR_W:0]           dd;

  logic signed [pwf_pkg::ERR_W-1:0]  err2_r;
  logic signed [pwf_pkg::SUM_W-1:0]  sum2_r;
  logic signed [pwf_pkg::ERR_W:0]    dd2_r;

  logic signed [36:0] p_prop, p_prop_r;
  logic signed [48:0] p_int, p_int_r;
  logic signed [37:0] p_der, p_der_r;

  logic [pwf_pkg::CTL_W-1:0] ctl_nxt, ctl_r, mag, rnd;
  logic [pwf_pkg::CTL_W-17:0] rq;
  logic [pwf_pkg::SPEED_W-1:0] red_nxt;

  assign dist_diff = $signed({{(pwf_pkg::DIFF_W-pwf_pkg::CFG_DIST_W){1'b0}}, target})
                   - $signed({{(pwf_pkg::DIFF_W-DISTANCE_BITS){1'b0}}, reading});

  always_comb begin
    if (dist_diff > 18'sd32767) begin
      err = 16'sh7FFF;
    end else if (dist_diff < -18'sd32768) begin
      err = 16'sh8000;
    end else begin
      err = dist_diff[pwf_pkg::ERR_W-1:0];
    end
  end

  assign sum_ext = {sum_r[pwf_pkg::SUM_W-1], sum_r}
                 + {{(pwf_pkg::SUM_W-pwf_pkg::ERR_W+1){err[pwf_pkg::ERR_W-1]}}, err};

  always_comb begin
    if (sum_ext[pwf_pkg::SUM_W] != sum_ext[pwf_pkg::SUM_W-1]) begin
      sum_nxt = sum_ext[pwf_pkg::SUM_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sum_nxt = sum_ext[pwf_pkg::SUM_W-1:0];
    end
  end

  assign dd = {err[pwf_pkg::ERR_W-1], err} - {last_r[pwf_pkg::ERR_W-1], last_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      last_r <= '0;
    end else if (adv.upd && wall) begin
      sum_r  <= sum_nxt;
      last_r <= err;
    end
  end

  // stage 2: error terms
  always_ff @(posedge clk) begin
    if (adv.ld2) begin
      err2_r <= err;
      sum2_r <= sum_nxt;
      dd2_r  <= dd;
    end
  end

  // stage 3: gain products
  assign p_prop = $signed({1'b0, prop}) * err2_r;
  assign p_int  = $signed({1'b0, intg}) * sum2_r;
  assign p_der  = $signed({1'b0, deriv}) * dd2_r;

  always_ff @(posedge clk) begin
    if (adv.ld3) begin
      p_prop_r <= p_prop;
      p_int_r  <= p_int;
      p_der_r  <= p_der;
    end
  end

  // stage 4: control value, Q.16
  assign ctl_nxt = {{13{p_prop_r[36]}}, p_prop_r}
                 + {p_int_r[48], p_int_r}
                 + {{12{p_der_r[37]}}, p_der_r};

  always_ff @(posedge clk) begin
    if (adv.ld4) begin
      ctl_r <= ctl_nxt;
    end
  end

  // stage 5: round magnitude, clamp to cruise
  assign mag = ctl_r[pwf_pkg::CTL_W-1] ? (~ctl_r + 50'd1) : ctl_r;
  assign rnd = mag + 50'd32768;
  assign rq  = rnd[pwf_pkg::CTL_W-1:16];

  always_comb begin
    if (rq > {{(pwf_pkg::CTL_W-16-pwf_pkg::SPEED_W){1'b0}}, cruise}) begin
      red_nxt = cruise;
    end else begin
      red_nxt = rq[pwf_pkg::SPEED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.ld5) begin
      red     <= red_nxt;
      ctl_pos <= !ctl_r[pwf_pkg::CTL_W-1] && (ctl_r != '0);
    end
  end

endmodule

### src/pid_wall_follower_core.sv
// Top level of the PID wall follower: config registers, pipeline control,
// command sequencing. Depends on pwf_pkg and pwf_pid.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid/in_ready, 3 range readings      | input item, one tick
//  out     | out_valid/out_ready, command fields/last | 1..4 commands per item
//  cfg     | cfg_wr_en, cfg_index, cfg_data           | register write
//
// Five-stage pipeline: input, error/integral, products, control sum, clamp.
// The first command of an item is presented once the item reaches stage 5. The
// output emits one command per cycle while out_ready is high, so an item gives
// 1 to 4 commands (2 per front wall, 1 per side wall, 1 when no side wall).
// Reset is synchronous; it clears PID state, following flags and stage valids.
// A stalled output backs the pipeline up stage by stage into in_ready.
module pid_wall_follower_core #(
  parameter int DISTANCE_BITS = 14
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [DISTANCE_BITS-1:0]          in_front_distance,
  input  logic [DISTANCE_BITS-1:0]          in_left_distance,
  input  logic [DISTANCE_BITS-1:0]          in_right_distance,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_command_kind,
  output logic [pwf_pkg::SPEED_W-1:0]       out_left_speed,
  output logic [pwf_pkg::SPEED_W-1:0]       out_right_speed,
  output logic signed [pwf_pkg::DEG_W-1:0]  out_turn_degrees,
  output logic                              out_last,
  input  logic                              cfg_wr_en,
  input  logic [pwf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pwf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [pwf_pkg::CFG_DIST_W-1:0] target_r, wall_r;
  logic [pwf_pkg::GAIN_W-1:0]     prop_r, deriv_r;
  logic [pwf_pkg::IGAIN_W-1:0]    intg_r;
  logic [pwf_pkg::SPEED_W-1:0]    cruise_r, wander_r;
  logic [pwf_pkg::ANGLE_W-1:0]    turn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= pwf_pkg::TARGET_RST;
      wall_r   <= pwf_pkg::WALL_RST;
      prop_r   <= pwf_pkg::PROP_RST;
      intg_r   <= pwf_pkg::INT_RST;
      deriv_r  <= pwf_pkg::DERIV_RST;
      cruise_r <= pwf_pkg::CRUISE_RST;
      wander_r <= pwf_pkg::WANDER_RST;
      turn_r   <= pwf_pkg::TURN_RST;
    end else if (cfg_wr_en) begin
      case (pwf_pkg::cfg_reg_t'(cfg_index))
        pwf_pkg::REG_TARGET: target_r <= cfg_data[pwf_pkg::CFG_DIST_W-1:0];
        pwf_pkg::REG_WALL:   wall_r   <= cfg_data[pwf_pkg::CFG_DIST_W-1:0];
        pwf_pkg::REG_PROP:   prop_r   <= cfg_data[pwf_pkg::GAIN_W-1:0];
        pwf_pkg::REG_INT:    intg_r   <= cfg_data[pwf_pkg::IGAIN_W-1:0];
        pwf_pkg::REG_DERIV:  deriv_r  <= cfg_data[pwf_pkg::GAIN_W-1:0];
        pwf_pkg::REG_CRUISE: cruise_r <= cfg_data[pwf_pkg::SPEED_W-1:0];
        pwf_pkg::REG_WANDER: wander_r <= cfg_data[pwf_pkg::SPEED_W-1:0];
        pwf_pkg::REG_TURN:   turn_r   <= cfg_data[pwf_pkg::ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline occupancy
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic free1, free2, free3, free4, free5;
  logic cmd_last;
  pwf_pkg::pwf_adv_t adv;

  assign free5 = !v5_r || (out_ready && cmd_last);
  assign free4 = !v4_r || free5;
  assign free3 = !v3_r || free4;
  assign free2 = !v2_r || free3;
  assign free1 = !v1_r || free2;
  assign in_ready = free1;

  assign adv.upd = v1_r && free2;
  assign adv.ld2 = free2;
  assign adv.ld3 = free3;
  assign adv.ld4 = free4;
  assign adv.ld5 = free5;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (free1) v1_r <= in_valid;
      if (free2) v2_r <= v1_r;
      if (free3) v3_r <= v2_r;
      if (free4) v4_r <= v3_r;
      if (free5) v5_r <= v4_r;
    end
  end

  // stage 1: input register
  logic [DISTANCE_BITS-1:0] front_r, left_r, right_r;

  always_ff @(posedge clk) begin
    if (free1) begin
      front_r <= in_front_distance;
      left_r  <= in_left_distance;
      right_r <= in_right_distance;
    end
  end

  logic [pwf_pkg::DIFF_W-1:0] wall_ext;
  logic front_wall, left_wall, right_wall;
  logic was_left_r, was_right_r;
  pwf_pkg::tick_flags_t flags, fl2_r, fl3_r, fl4_r, fl5_r;

  assign wall_ext   = {{(pwf_pkg::DIFF_W-pwf_pkg::CFG_DIST_W){1'b0}}, wall_r};
  assign front_wall = {{(pwf_pkg::DIFF_W-DISTANCE_BITS){1'b0}}, front_r} < wall_ext;
  assign left_wall  = {{(pwf_pkg::DIFF_W-DISTANCE_BITS){1'b0}}, left_r} < wall_ext;
  assign right_wall = {{(pwf_pkg::DIFF_W-DISTANCE_BITS){1'b0}}, right_r} < wall_ext;

  always_comb begin
    flags.front_wall = front_wall;
    flags.left_wall  = left_wall;
    flags.right_wall = right_wall;
    if (was_left_r) begin
      flags.idle_cmd = pwf_pkg::IDLE_TURN_POS;
    end else if (was_right_r) begin
      flags.idle_cmd = pwf_pkg::IDLE_TURN_NEG;
    end else begin
      flags.idle_cmd = pwf_pkg::IDLE_WANDER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_left_r  <= 1'b0;
      was_right_r <= 1'b0;
    end else if (adv.upd) begin
      if (right_wall) begin
        was_left_r  <= 1'b0;
        was_right_r <= 1'b1;
      end else if (left_wall) begin
        was_left_r  <= 1'b1;
        was_right_r <= 1'b0;
      end else begin
        was_left_r  <= 1'b0;
        was_right_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free2) fl2_r <= flags;
    if (free3) fl3_r <= fl2_r;
    if (free4) fl4_r <= fl3_r;
    if (free5) fl5_r <= fl4_r;
  end

  logic [pwf_pkg::SPEED_W-1:0] left_red, right_red;
  logic left_pos, right_pos;

  pwf_pid #(.DISTANCE_BITS(DISTANCE_BITS)) u_left_pid (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .wall    (left_wall),
    .reading (left_r),
    .target  (target_r),
    .prop    (prop_r),
    .intg    (intg_r),
    .deriv   (deriv_r),
    .cruise  (cruise_r),
    .red     (left_red),
    .ctl_pos (left_pos)
  );

  pwf_pid #(.DISTANCE_BITS(DISTANCE_BITS)) u_right_pid (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .wall    (right_wall),
    .reading (right_r),
    .target  (target_r),
    .prop    (prop_r),
    .intg    (intg_r),
    .deriv   (deriv_r),
    .cruise  (cruise_r),
    .red     (right_red),
    .ctl_pos (right_pos)
  );

  // command sequencing out of stage 5
  logic [pwf_pkg::CMD_IDX_W-1:0] idx_r;
  logic [pwf_pkg::CMD_CNT_W-1:0] cmd_cnt, pos, p_side, p_right;
  logic no_side;
  pwf_pkg::cmd_t cmd;
  logic signed [pwf_pkg::DEG_W-1:0] turn_pos, turn_neg;

  assign no_side = !fl5_r.left_wall && !fl5_r.right_wall;
  assign cmd_cnt = {1'b0, fl5_r.front_wall, 1'b0}
                 + {2'b00, fl5_r.left_wall}
                 + {2'b00, fl5_r.right_wall}
                 + {2'b00, no_side};
  assign pos      = {1'b0, idx_r};
  assign cmd_last = (pos == cmd_cnt - 3'd1);
  assign p_side   = pos - {1'b0, fl5_r.front_wall, 1'b0};
  assign p_right  = p_side - {2'b00, fl5_r.left_wall};

  always_comb begin
    if (fl5_r.front_wall && (pos == 3'd0)) begin
      cmd = pwf_pkg::CMD_STOP;
    end else if (fl5_r.front_wall && (pos == 3'd1)) begin
      cmd = pwf_pkg::CMD_FTURN;
    end else if (fl5_r.left_wall && (p_side == 3'd0)) begin
      cmd = pwf_pkg::CMD_LEFT;
    end else if (fl5_r.right_wall && (p_right == 3'd0)) begin
      cmd = pwf_pkg::CMD_RIGHT;
    end else begin
      cmd = pwf_pkg::CMD_IDLE;
    end
  end

  assign turn_pos = $signed({1'b0, turn_r});
  assign turn_neg = -turn_pos;

  always_comb begin
    out_command_kind = pwf_pkg::KIND_SPEED;
    out_left_speed   = '0;
    out_right_speed  = '0;
    out_turn_degrees = '0;
    case (cmd)
      pwf_pkg::CMD_STOP: ;
      pwf_pkg::CMD_FTURN: begin
        out_command_kind = pwf_pkg::KIND_TURN;
        out_turn_degrees = fl5_r.right_wall ? turn_pos : turn_neg;
      end
      pwf_pkg::CMD_LEFT: begin
        out_left_speed  = left_pos ? cruise_r - left_red : cruise_r;
        out_right_speed = left_pos ? cruise_r : cruise_r - left_red;
      end
      pwf_pkg::CMD_RIGHT: begin
        out_left_speed  = right_pos ? cruise_r - right_red : cruise_r;
        out_right_speed = right_pos ? cruise_r : cruise_r - right_red;
      end
      pwf_pkg::CMD_IDLE: begin
        case (fl5_r.idle_cmd)
          pwf_pkg::IDLE_TURN_POS: begin
            out_command_kind = pwf_pkg::KIND_TURN;
            out_turn_degrees = turn_pos;
          end
          pwf_pkg::IDLE_TURN_NEG: begin
            out_command_kind = pwf_pkg::KIND_TURN;
            out_turn_degrees = turn_neg;
          end
          default: begin
            out_left_speed  = wander_r;
            out_right_speed = wander_r;
          end
        endcase
      end
      default: ;
    endcase
  end

  assign out_valid = v5_r;
  assign out_last  = cmd_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (out_valid && out_ready) begin
      idx_r <= cmd_last ? '0 : idx_r + 2'd1;
    end
  end

  a_follow_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(was_left_r && was_right_r))
    else $error("both following flags set");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, idx_r} < cmd_cnt))
    else $error("command index beyond command count");

  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=>
      (out_valid && (idx_r == $past(idx_r) + 2'd1)))
    else $error("item dropped before its last command");

  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> (idx_r == '0))
    else $error("command index not cleared between items");

endmodule

### test/pwf_command_checker.sv
// Command checker for the PID wall follower core: tracks register writes,
// predicts the commands of each accepted range item and compares them in order.
// Depends on pwf_pkg.
`timescale 1ns / 1ps

module pwf_command_checker #(
  parameter int DIST_W = 14
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [DIST_W-1:0]                  in_front_distance,
  input  logic [DIST_W-1:0]                  in_left_distance,
  input  logic [DIST_W-1:0]                  in_right_distance,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic                               out_command_kind,
  input  logic [pwf_pkg::SPEED_W-1:0]        out_left_speed,
  input  logic [pwf_pkg::SPEED_W-1:0]        out_right_speed,
  input  logic signed [pwf_pkg::DEG_W-1:0]   out_turn_degrees,
  input  logic                               out_last,
  input  logic                               cfg_wr_en,
  input  logic [pwf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pwf_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                 cmds_pending,
  output int                                 mismatch_count
);
  import pwf_pkg::*;

  typedef struct packed {
    logic                      kind;
    logic [SPEED_W-1:0]        left_speed;
    logic [SPEED_W-1:0]        right_speed;
    logic signed [DEG_W-1:0]   turn_degrees;
    logic                      last;
  } wheel_cmd_t;

  localparam int SIDE_L = 0;
  localparam int SIDE_R = 1;

  logic [CFG_DIST_W-1:0] target_mm, wall_mm;
  logic [GAIN_W-1:0]     kp, kd;
  logic [IGAIN_W-1:0]    ki;
  logic [SPEED_W-1:0]    cruise, wander;
  logic [ANGLE_W-1:0]    turn;

  int                    err_sum [2];
  logic signed [ERR_W-1:0] prev_err [2];
  logic                  follow_l, follow_r;

  wheel_cmd_t            expected_cmds [$];
  wheel_cmd_t            got, want;
  int                    n_bad = 0;

  function automatic wheel_cmd_t make_cmd(logic kind, logic [SPEED_W-1:0] ls,
                                          logic [SPEED_W-1:0] rs,
                                          logic signed [DEG_W-1:0] deg);
    wheel_cmd_t c;
    c.kind         = kind;
    c.left_speed   = ls;
    c.right_speed  = rs;
    c.turn_degrees = deg;
    c.last         = 1'b0;
    return c;
  endfunction

  // one PID step on a side, returns the wheel speed command
  function automatic wheel_cmd_t follow_wall(int side, logic [DIST_W-1:0] reading);
    longint     e, s, ctl, mag, r;
    wheel_cmd_t c;
    e = longint'(target_mm) - longint'(reading);
    if (e > 64'sd32767) e = 64'sd32767;
    else if (e < -64'sd32768) e = -64'sd32768;
    s = longint'(err_sum[side]) + e;
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    else if (s < -64'sd2147483648) s = -64'sd2147483648;
    ctl = longint'(kp) * e + longint'(ki) * s
        + longint'(kd) * (e - longint'(prev_err[side]));
    err_sum[side]  = int'(s);
    prev_err[side] = ERR_W'(e);
    mag = (ctl < 0) ? -ctl : ctl;
    r = (mag + 64'sd32768) >>> 16;
    if (r > longint'(cruise)) r = longint'(cruise);
    c = make_cmd(KIND_SPEED, cruise, cruise, '0);
    if (ctl > 0) c.left_speed = cruise - SPEED_W'(r);
    else c.right_speed = cruise - SPEED_W'(r);
    return c;
  endfunction

  task automatic predict_tick(logic [DIST_W-1:0] f, logic [DIST_W-1:0] l,
                              logic [DIST_W-1:0] r);
    logic                    fw, lw, rw;
    logic signed [DEG_W-1:0] t;
    wheel_cmd_t              cmds [4];
    int                      n;
    fw = f < wall_mm;
    lw = l < wall_mm;
    rw = r < wall_mm;
    t  = {1'b0, turn};
    n  = 0;
    if (fw) begin
      cmds[n] = make_cmd(KIND_SPEED, '0, '0, '0);
      n++;
      cmds[n] = make_cmd(KIND_TURN, '0, '0, rw ? t : -t);
      n++;
    end
    if (lw) begin
      follow_l = 1'b1;
      follow_r = 1'b0;
      cmds[n]  = follow_wall(SIDE_L, l);
      n++;
    end
    if (rw) begin
      follow_r = 1'b1;
      follow_l = 1'b0;
      cmds[n]  = follow_wall(SIDE_R, r);
      n++;
    end
    if (!lw && !rw) begin
      if (follow_l) begin
        cmds[n]  = make_cmd(KIND_TURN, '0, '0, t);
        follow_l = 1'b0;
      end else if (follow_r) begin
        cmds[n]  = make_cmd(KIND_TURN, '0, '0, -t);
        follow_r = 1'b0;
      end else begin
        cmds[n] = make_cmd(KIND_SPEED, wander, wander, '0);
      end
      n++;
    end
    cmds[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_cmds.push_back(cmds[i]);
  endtask

  task automatic compare_cmd(wheel_cmd_t c);
    if (expected_cmds.size() == 0) begin
      $error("command with no item pending: kind %0d", c.kind);
      n_bad++;
    end else begin
      want = expected_cmds.pop_front();
      if (c.kind != want.kind) begin
        $error("command_kind: expected %0d, got %0d", want.kind, c.kind);
        n_bad++;
      end
      if (c.left_speed != want.left_speed) begin
        $error("left_speed: expected %0d, got %0d", want.left_speed, c.left_speed);
        n_bad++;
      end
      if (c.right_speed != want.right_speed) begin
        $error("right_speed: expected %0d, got %0d", want.right_speed, c.right_speed);
        n_bad++;
      end
      if (c.turn_degrees != want.turn_degrees) begin
        $error("turn_degrees: expected %0d, got %0d", want.turn_degrees, c.turn_degrees);
        n_bad++;
      end
      if (c.last != want.last) begin
        $error("last: expected %0d, got %0d", want.last, c.last);
        n_bad++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      target_mm = TARGET_RST;
      wall_mm   = WALL_RST;
      kp        = PROP_RST;
      ki        = INT_RST;
      kd        = DERIV_RST;
      cruise    = CRUISE_RST;
      wander    = WANDER_RST;
      turn      = TURN_RST;
      err_sum[SIDE_L]  = 0;
      err_sum[SIDE_R]  = 0;
      prev_err[SIDE_L] = '0;
      prev_err[SIDE_R] = '0;
      follow_l  = 1'b0;
      follow_r  = 1'b0;
      expected_cmds.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_TARGET: target_mm = cfg_data[CFG_DIST_W-1:0];
          REG_WALL:   wall_mm   = cfg_data[CFG_DIST_W-1:0];
          REG_PROP:   kp        = cfg_data[GAIN_W-1:0];
          REG_INT:    ki        = cfg_data[IGAIN_W-1:0];
          REG_DERIV:  kd        = cfg_data[GAIN_W-1:0];
          REG_CRUISE: cruise    = cfg_data[SPEED_W-1:0];
          REG_WANDER: wander    = cfg_data[SPEED_W-1:0];
          REG_TURN:   turn      = cfg_data[ANGLE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = make_cmd(out_command_kind, out_left_speed, out_right_speed, out_turn_degrees);
        got.last = out_last;
        compare_cmd(got);
      end
      if (in_valid && in_ready)
        predict_tick(in_front_distance, in_left_distance, in_right_distance);
    end
    cmds_pending   <= expected_cmds.size();
    mismatch_count <= n_bad;
  end

endmodule

### test/pid_wall_follower_core_tb.sv
// Testbench top for pid_wall_follower_core: drives range items and register
// writes, applies output back-pressure and reports the verdict.
// Depends on pwf_pkg, pid_wall_follower_core and pwf_command_checker.
`timescale 1ns / 1ps

module pid_wall_follower_core_tb;
  import pwf_pkg::*;

  localparam int DIST_W      = 14;
  localparam int DIST_MAX    = 16383;
  localparam int LIMIT       = 400000;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE      = 20;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [DIST_W-1:0]         in_front_distance = '0;
  logic [DIST_W-1:0]         in_left_distance = '0;
  logic [DIST_W-1:0]         in_right_distance = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      out_command_kind;
  logic [SPEED_W-1:0]        out_left_speed, out_right_speed;
  logic signed [DEG_W-1:0]   out_turn_degrees;
  logic                      out_last;
  logic                      cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = REG_TARGET;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  int                        cmds_pending, mismatch_count;
  int                        gap_max = 7;
  int                        stall_max = 7;
  bit                        hold_req = 1'b0;
  bit                        hold_done = 1'b0;
  int                        cycle_count = 0;
  logic [CFG_DIST_W-1:0]     cur_target = TARGET_RST;
  logic [CFG_DIST_W-1:0]     cur_wall = WALL_RST;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pid_wall_follower_core #(.DISTANCE_BITS(DIST_W)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_front_distance(in_front_distance),
    .in_left_distance(in_left_distance),
    .in_right_distance(in_right_distance),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_command_kind(out_command_kind),
    .out_left_speed(out_left_speed), .out_right_speed(out_right_speed),
    .out_turn_degrees(out_turn_degrees), .out_last(out_last),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pwf_command_checker #(.DIST_W(DIST_W)) u_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_front_distance(in_front_distance),
    .in_left_distance(in_left_distance),
    .in_right_distance(in_right_distance),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_command_kind(out_command_kind),
    .out_left_speed(out_left_speed), .out_right_speed(out_right_speed),
    .out_turn_degrees(out_turn_degrees), .out_last(out_last),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmds_pending(cmds_pending), .mismatch_count(mismatch_count)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random stall per command, long hold-off on request
  initial begin
    int stall;
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = int'($urandom_range(stall_max, 0));
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_config(logic [CFG_DATA_W-1:0] tgt, logic [CFG_DATA_W-1:0] wal,
                             logic [CFG_DATA_W-1:0] p, logic [CFG_DATA_W-1:0] i,
                             logic [CFG_DATA_W-1:0] d, logic [CFG_DATA_W-1:0] cr,
                             logic [CFG_DATA_W-1:0] wd, logic [CFG_DATA_W-1:0] tn);
    write_reg(REG_TARGET, tgt);
    write_reg(REG_WALL, wal);
    write_reg(REG_PROP, p);
    write_reg(REG_INT, i);
    write_reg(REG_DERIV, d);
    write_reg(REG_CRUISE, cr);
    write_reg(REG_WANDER, wd);
    write_reg(REG_TURN, tn);
    cfg_wr_en  <= 1'b0;
    cur_target = tgt[CFG_DIST_W-1:0];
    cur_wall   = wal[CFG_DIST_W-1:0];
  endtask

  task automatic random_config();
    logic [CFG_DATA_W-1:0] tgt, wal, p, i, d, cr, wd, tn;
    int                    w;
    if ($urandom_range(3, 0) == 0) tgt = CFG_DATA_W'($urandom);
    else tgt = CFG_DATA_W'($urandom_range(3000, 300));
    w = int'(tgt[CFG_DIST_W-1:0]) + int'($urandom_range(2500, 50));
    wal = (w > DIST_MAX) ? CFG_DATA_W'(DIST_MAX) : CFG_DATA_W'(w);
    if ($urandom_range(2, 0) == 0) begin
      p = CFG_DATA_W'($urandom);
      i = CFG_DATA_W'($urandom);
      d = CFG_DATA_W'($urandom);
    end else begin
      p = CFG_DATA_W'($urandom_range(262143, 0));
      i = CFG_DATA_W'($urandom_range(2000, 0));
      d = CFG_DATA_W'($urandom_range(262143, 0));
    end
    if ($urandom_range(3, 0) == 0) cr = CFG_DATA_W'($urandom);
    else cr = CFG_DATA_W'($urandom_range(600, 50));
    wd = CFG_DATA_W'($urandom);
    if ($urandom_range(3, 0) == 0) tn = CFG_DATA_W'($urandom);
    else tn = CFG_DATA_W'($urandom_range(180, 0));
    load_config(tgt, wal, p, i, d, cr, wd, tn);
  endtask

  task automatic send_tick(int f, int l, int r);
    int gap;
    gap = int'($urandom_range(gap_max, 0));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_front_distance <= DIST_W'(f);
    in_left_distance  <= DIST_W'(l);
    in_right_distance <= DIST_W'(r);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (cmds_pending != 0) @(posedge clk);
  endtask

  function automatic int far_range();
    return int'($urandom_range(DIST_MAX, int'(cur_wall)));
  endfunction

  function automatic int near_wall();
    if (cur_wall == 0) return 0;
    return int'($urandom_range(int'(cur_wall) - 1, 0));
  endfunction

  function automatic int near_target();
    int v;
    v = int'(cur_target) + int'($urandom_range(600, 0)) - 300;
    if (v < 0) v = 0;
    if (v > DIST_MAX) v = DIST_MAX;
    return v;
  endfunction

  function automatic int any_range();
    return int'($urandom_range(DIST_MAX, 0));
  endfunction

  // runs of ticks that look like one situation: following, corner, open space or random
  task automatic random_ticks(int count);
    int mode, run;
    run = 0;
    repeat (count) begin
      if (run == 0) begin
        mode = int'($urandom_range(4, 0));
        run  = int'($urandom_range(10, 1));
      end
      run--;
      case (mode)
        0: send_tick(far_range(), near_target(), far_range());
        1: send_tick(far_range(), far_range(), near_target());
        2: send_tick(near_wall(), any_range(), near_target());
        3: send_tick(far_range(), far_range(), far_range());
        default: send_tick(any_range(), any_range(), any_range());
      endcase
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: target 1000, wall below 1500, turn 45
    send_tick(16383, 16383, 16383);
    send_tick(0, 16383, 16383);
    send_tick(0, 0, 0);
    send_tick(16383, 16383, 16383);
    send_tick(1500, 1499, 1500);
    send_tick(16383, 16383, 16383);
    send_tick(16383, 1200, 16383);
    send_tick(16383, 1200, 16383);
    send_tick(16383, 1200, 16383);
    send_tick(16383, 1400, 16383);
    send_tick(16383, 16383, 0);
    send_tick(16383, 16383, 1000);
    send_tick(16383, 16383, 1450);
    send_tick(16383, 0, 16383);
    send_tick(1499, 16383, 1499);
    send_tick(1499, 1499, 16383);
    drain();

    // all-ones data: every register at its top value, turn 255
    load_config('1, '1, '1, '1, '1, '1, '1, '1);
    send_tick(0, 0, 0);
    send_tick(16382, 16382, 16382);
    send_tick(16383, 16383, 16383);
    send_tick(16383, 16383, 16383);
    send_tick(16383, 0, 16383);
    drain();

    // all zero: no wall can be seen
    load_config('0, '0, '0, '0, '0, '0, '0, '0);
    send_tick(0, 0, 0);
    send_tick(16383, 16383, 16383);
    drain();

    for (int p = 0; p < 5; p++) begin
      random_config();
      gap_max   = (p == 1) ? 0 : 7;
      stall_max = (p == 1) ? 0 : 7;
      if (p == 3) begin
        hold_req = 1'b1;
        gap_max  = 0;
        random_ticks(24);
        gap_max  = 7;
        random_ticks(28);
      end else begin
        random_ticks(52);
      end
      drain();
    end

    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0 && cmds_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
